@@ src/btzcc_pkg.sv @@
// Package for the battery thermal zone charge control core.
// Holds operation, status, action and register codes, port widths and defaults.
// No dependencies; used by the top level.
package btzcc_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TEMP_BITS_DEF   = 12;

  // Fixed field widths
  localparam int FIELD_TEMP_W = 12;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int COUNT_W      = 5;
  localparam int S_TDATA_W    = 48;
  localparam int S_TUSER_W    = 5;
  localparam int M_TDATA_W    = 72;
  localparam int M_TUSER_W    = 2;

  // Operation codes
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_WARM    = 3'd2;
  localparam logic [2:0] OP_COOL    = 3'd3;
  localparam logic [2:0] OP_CHARGER = 3'd4;

  // Table selects
  localparam logic [1:0] TBL_WIRED_WARM = 2'd0;
  localparam logic [1:0] TBL_WL_WARM    = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_REARMED   = 2'd0;
  localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
  localparam logic [1:0] STATUS_STORED    = 2'd2;

  // Charge actions
  localparam logic [1:0] ACT_ENABLE   = 2'd0;
  localparam logic [1:0] ACT_DECREASE = 2'd1;
  localparam logic [1:0] ACT_STOP     = 2'd2;
  localparam logic [1:0] ACT_SHUTDOWN = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_NOM_CUR  = 3'd0;
  localparam logic [2:0] REG_NOM_VOLT = 3'd1;
  localparam logic [2:0] REG_RED_CUR  = 3'd2;
  localparam logic [2:0] REG_RED_VOLT = 3'd3;
  localparam logic [2:0] REG_WARM_CNT = 3'd4;
  localparam logic [2:0] REG_COOL_CNT = 3'd5;
  localparam logic [2:0] REG_WARM_WL  = 3'd6;
  localparam logic [2:0] REG_COOL_WL  = 3'd7;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_APPLY  = 3'b100
  } state_t;

endpackage

@@ src/btzcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the zone table storage.
module btzcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/battery_thermal_zone_charge_control_core.sv @@
// Top level of the battery thermal zone charge control core.
// Depends on btzcc_pkg and btzcc_ram (zone table storage).
//
// Four zone tables (wired warm, wired cool, wireless warm, wireless cool) live in one
// RAM of 4*TABLE_DEPTH entries that is undefined until loaded: load every entry that a
// search can reach (up to each table's count, and entry 0 of both warm tables) before
// sending crossing, start or charger items. One item is in flight at a time. A load
// item or an item that changes nothing goes straight to the apply state; start and
// charger re-arm items read entry 0 first; a crossing reads one table entry per cycle
// from the RAM's single read port, from the last used entry down to the matching entry
// or entry 0. A result that is not taken holds the block in its apply state; the next
// item is accepted while a finished result still waits in the output register.
module battery_thermal_zone_charge_control_core
  import btzcc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int TEMP_BITS   = TEMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // entry_index[3:0], entry_threshold[15:4], entry_next_low[27:16],
  // entry_next_high[39:28], entry_action[41:40], entry_health[45:42],
  // wireless_online[46], wired_online[47]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // operation[2:0], table_select[4:3]
  input  logic [S_TUSER_W-1:0] s_tuser,
  // Result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // low_threshold[11:0], high_threshold[23:12], action[25:24], health[29:26],
  // health_valid[30], charge_enable[31], limits_valid[32], current_limit_ma[48:33],
  // voltage_limit_mv[64:49], shutdown_request[65], using_wireless_tables[66], zeros above
  output logic [M_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [M_TUSER_W-1:0] m_tuser,
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int TB      = TEMP_BITS;
  localparam int SLOTS   = 4 * TABLE_DEPTH;
  localparam int AW      = $clog2(SLOTS);
  localparam int IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int SW      = (CW > COUNT_W) ? CW : COUNT_W;
  // Entry layout, lowest bits first
  localparam int THR_LO  = 0;
  localparam int NLOW_LO = TB;
  localparam int NHI_LO  = 2 * TB;
  localparam int ACT_LO  = 3 * TB;
  localparam int HLTH_LO = 3 * TB + 2;
  localparam int EW      = 3 * TB + 6;

  // Zero-extend or truncate a 12-bit port temperature to the stored width
  function automatic logic [TB-1:0] to_temp(input logic [FIELD_TEMP_W-1:0] v);
    logic [TB-1:0] r;
    for (int b = 0; b < TB; b++) begin
      r[b] = (b < FIELD_TEMP_W) ? v[b % FIELD_TEMP_W] : 1'b0;
    end
    return r;
  endfunction

  // Stored temperature back to the 12-bit port field
  function automatic logic [FIELD_TEMP_W-1:0] from_temp(input logic [TB-1:0] v);
    logic [FIELD_TEMP_W-1:0] r;
    for (int b = 0; b < FIELD_TEMP_W; b++) begin
      r[b] = (b < TB) ? v[b % TB] : 1'b0;
    end
    return r;
  endfunction

  // RAM address of an entry of one table
  function automatic logic [AW-1:0] slot_addr(input logic [1:0] tbl, input int unsigned i);
    return AW'(int'(tbl) * TABLE_DEPTH + i);
  endfunction

  // Clamp a table count to the table depth, return the first index to search
  function automatic logic [IW-1:0] first_index(input logic [COUNT_W-1:0] cnt);
    logic [SW-1:0] sz;
    logic [SW-1:0] sz_m1;
    sz    = (SW'(cnt) > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(cnt);
    sz_m1 = sz - SW'(1);
    return (sz == '0) ? '0 : sz_m1[IW-1:0];
  endfunction

  // Input fields
  logic [2:0]              operation;
  logic [1:0]              table_select;
  logic [3:0]              entry_index;
  logic [FIELD_TEMP_W-1:0] entry_threshold;
  logic [FIELD_TEMP_W-1:0] entry_next_low;
  logic [FIELD_TEMP_W-1:0] entry_next_high;
  logic [1:0]              entry_action;
  logic [3:0]              entry_health;
  logic                    wireless_online;
  logic                    wired_online;

  assign operation       = s_tuser[2:0];
  assign table_select    = s_tuser[4:3];
  assign entry_index     = s_tdata[3:0];
  assign entry_threshold = s_tdata[15:4];
  assign entry_next_low  = s_tdata[27:16];
  assign entry_next_high = s_tdata[39:28];
  assign entry_action    = s_tdata[41:40];
  assign entry_health    = s_tdata[45:42];
  assign wireless_online = s_tdata[46];
  assign wired_online    = s_tdata[47];

  // Configuration registers
  logic [CFG_W-1:0]   nominal_current_ma;
  logic [CFG_W-1:0]   nominal_voltage_mv;
  logic [CFG_W-1:0]   reduced_current_ma;
  logic [CFG_W-1:0]   reduced_voltage_mv;
  logic [COUNT_W-1:0] warm_count;
  logic [COUNT_W-1:0] cool_count;
  logic [COUNT_W-1:0] warm_count_wireless;
  logic [COUNT_W-1:0] cool_count_wireless;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_current_ma  <= '0;
      nominal_voltage_mv  <= '0;
      reduced_current_ma  <= '0;
      reduced_voltage_mv  <= '0;
      warm_count          <= COUNT_W'(1);
      cool_count          <= COUNT_W'(1);
      warm_count_wireless <= '0;
      cool_count_wireless <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOM_CUR:  nominal_current_ma  <= cfg_data;
        REG_NOM_VOLT: nominal_voltage_mv  <= cfg_data;
        REG_RED_CUR:  reduced_current_ma  <= cfg_data;
        REG_RED_VOLT: reduced_voltage_mv  <= cfg_data;
        REG_WARM_CNT: warm_count          <= cfg_data[COUNT_W-1:0];
        REG_COOL_CNT: cool_count          <= cfg_data[COUNT_W-1:0];
        REG_WARM_WL:  warm_count_wireless <= cfg_data[COUNT_W-1:0];
        REG_COOL_WL:  cool_count_wireless <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and armed state
  state_t           state;
  logic [2:0]       op_q;
  logic [1:0]       tbl_q;
  logic [TB-1:0]    key_q;
  logic [IW-1:0]    i_cur;
  logic             rearm_q;
  logic [EW-1:0]    hit_q;
  logic [TB-1:0]    armed_low;
  logic [TB-1:0]    armed_high;
  logic             wireless_param_flag;
  logic             wireless_present;
  logic             wired_present;
  logic             charge_on;

  logic             accept;
  logic             apply_fire;
  logic             wl_use;
  logic             warm;
  logic [COUNT_W-1:0] cnt_sel;
  logic [1:0]       srch_tbl;
  logic [IW-1:0]    srch_first;
  logic             wl_new;
  logic             wd_new;
  logic             wd_change;
  logic             changed;
  logic             rearm;
  logic             needs_read;
  logic             load_ok;

  // Zone table RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  logic             srch_done;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Decode of the offered item
  always_comb begin
    wl_use     = wireless_param_flag && (warm_count_wireless != '0) &&
                 (cool_count_wireless != '0);
    warm       = (operation == OP_WARM);
    cnt_sel    = warm ? (wl_use ? warm_count_wireless : warm_count)
                      : (wl_use ? cool_count_wireless : cool_count);
    srch_tbl   = {wl_use, !warm};
    srch_first = first_index(cnt_sel);
    // Charger presence: wired is only taken while wireless is offline
    wl_new     = wireless_online;
    wd_change  = !wl_new && (wired_online != wired_present);
    wd_new     = wd_change ? wired_online : wired_present;
    changed    = (wl_new != wireless_present) || wd_change;
    rearm      = changed && (wl_new || wd_new);
    needs_read = (operation == OP_START) || (operation == OP_WARM) ||
                 (operation == OP_COOL) || ((operation == OP_CHARGER) && rearm);
    load_ok    = (operation == OP_LOAD) && (32'(entry_index) < TABLE_DEPTH);
  end

  // Table writes happen only in idle, reads of other items never overlap them
  assign ram_we    = accept && load_ok;
  assign ram_waddr = slot_addr(table_select, 32'(entry_index));
  assign ram_wdata = {entry_health, entry_action, to_temp(entry_next_high),
                      to_temp(entry_next_low), to_temp(entry_threshold)};

  // Read address: first entry on accept, next lower entry while searching
  always_comb begin
    if (state == ST_SEARCH) begin
      ram_raddr = slot_addr(tbl_q, 32'(i_cur - IW'(1)));
    end else begin
      priority case (1'b1)
        (operation == OP_WARM) || (operation == OP_COOL):
          ram_raddr = slot_addr(srch_tbl, 32'(srch_first));
        (operation == OP_CHARGER) && wl_new:
          ram_raddr = slot_addr(TBL_WL_WARM, 0);
        default:
          ram_raddr = slot_addr(TBL_WIRED_WARM, 0);
      endcase
    end
  end

  btzcc_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS),
    .AW   (AW)
  ) u_zone_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Search ends on a threshold match or at entry 0
  assign srch_done  = (i_cur == '0) || (ram_rdata[THR_LO +: TB] == key_q);
  assign apply_fire = (state == ST_APPLY) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      wireless_present <= 1'b0;
      wired_present    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= needs_read ? ST_SEARCH : ST_APPLY;
            if (operation == OP_CHARGER) begin
              wireless_present <= wl_new;
              wired_present    <= wd_new;
            end
          end
        end
        ST_SEARCH: begin
          if (srch_done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item registers and search index
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      tbl_q   <= srch_tbl;
      key_q   <= warm ? armed_high : armed_low;
      rearm_q <= rearm;
      i_cur   <= ((operation == OP_WARM) || (operation == OP_COOL)) ? srch_first : '0;
    end else if (state == ST_SEARCH) begin
      if (srch_done) begin
        hit_q <= ram_rdata;
      end else begin
        i_cur <= i_cur - IW'(1);
      end
    end
  end

  // Result of the chosen entry
  logic [1:0]        status_n;
  logic [1:0]        action_n;
  logic [3:0]        health_n;
  logic              hvalid_n;
  logic              lvalid_n;
  logic              shut_n;
  logic [CFG_W-1:0]  cur_n;
  logic [CFG_W-1:0]  volt_n;
  logic [TB-1:0]     armed_low_next;
  logic [TB-1:0]     armed_high_next;
  logic              charge_on_next;
  logic              flag_next;
  logic [1:0]        hit_act;

  assign hit_act = hit_q[ACT_LO +: 2];

  always_comb begin
    status_n        = STATUS_NO_CHANGE;
    action_n        = ACT_ENABLE;
    health_n        = '0;
    hvalid_n        = 1'b0;
    lvalid_n        = 1'b0;
    shut_n          = 1'b0;
    cur_n           = '0;
    volt_n          = '0;
    armed_low_next  = armed_low;
    armed_high_next = armed_high;
    charge_on_next  = charge_on;
    flag_next       = wireless_param_flag;
    priority case (1'b1)
      (op_q == OP_LOAD): begin
        status_n = STATUS_STORED;
      end
      (op_q == OP_START): begin
        status_n        = STATUS_REARMED;
        armed_low_next  = hit_q[NLOW_LO +: TB];
        armed_high_next = hit_q[NHI_LO +: TB];
      end
      (op_q == OP_WARM) || (op_q == OP_COOL): begin
        status_n        = STATUS_REARMED;
        armed_low_next  = hit_q[NLOW_LO +: TB];
        armed_high_next = hit_q[NHI_LO +: TB];
        action_n        = hit_act;
        health_n        = hit_q[HLTH_LO +: 4];
        hvalid_n        = 1'b1;
        unique case (hit_act)
          ACT_ENABLE: begin
            charge_on_next = 1'b1;
            lvalid_n       = 1'b1;
            cur_n          = nominal_current_ma;
            volt_n         = nominal_voltage_mv;
          end
          ACT_DECREASE: begin
            charge_on_next = 1'b1;
            lvalid_n       = 1'b1;
            cur_n          = reduced_current_ma;
            volt_n         = reduced_voltage_mv;
          end
          ACT_STOP:     charge_on_next = 1'b0;
          ACT_SHUTDOWN: shut_n = 1'b1;
          default: ;
        endcase
      end
      (op_q == OP_CHARGER) && rearm_q: begin
        // Plug-in: nominal charging, arm from warm entry 0 of the active charger
        status_n        = STATUS_REARMED;
        charge_on_next  = 1'b1;
        lvalid_n        = 1'b1;
        cur_n           = nominal_current_ma;
        volt_n          = nominal_voltage_mv;
        armed_low_next  = hit_q[NLOW_LO +: TB];
        armed_high_next = hit_q[NHI_LO +: TB];
        flag_next       = wireless_present;
      end
      default: ;
    endcase
  end

  // Armed state update
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_low           <= '0;
      armed_high          <= '0;
      charge_on           <= 1'b0;
      wireless_param_flag <= 1'b0;
    end else if (apply_fire) begin
      armed_low           <= armed_low_next;
      armed_high          <= armed_high_next;
      charge_on           <= charge_on_next;
      wireless_param_flag <= flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      m_tuser <= status_n;
      m_tdata <= {5'd0,
                  flag_next && (warm_count_wireless != '0) && (cool_count_wireless != '0),
                  shut_n, volt_n, cur_n, lvalid_n, charge_on_next, hvalid_n,
                  health_n, action_n, from_temp(armed_high_next),
                  from_temp(armed_low_next)};
    end
  end

endmodule

@@ verif/btzcc_check_pkg.sv @@
// Result prediction and checking for the battery thermal zone charge control core.
// Holds the item and result types and the scoreboard class; depends on btzcc_pkg.
package btzcc_check_pkg;
  import btzcc_pkg::*;

  // One stored zone table entry
  typedef struct {
    logic [FIELD_TEMP_W-1:0] thr;
    logic [FIELD_TEMP_W-1:0] nlow;
    logic [FIELD_TEMP_W-1:0] nhigh;
    logic [1:0]              act;
    logic [3:0]              hlth;
  } zone_entry_t;

  // One result item, field by field
  typedef struct {
    logic [1:0]              status;
    logic [FIELD_TEMP_W-1:0] low_thr;
    logic [FIELD_TEMP_W-1:0] high_thr;
    logic [1:0]              action;
    logic [3:0]              health;
    logic                    health_valid;
    logic                    charge_enable;
    logic                    limits_valid;
    logic [15:0]             cur_limit;
    logic [15:0]             voltage_mv;
    logic                    shutdown_req;
    logic                    wireless_tables;
    logic [4:0]              pad;
  } charge_result_t;

  class zone_check_board;
    zone_entry_t             zones[4*TABLE_DEPTH_DEF];
    logic [FIELD_TEMP_W-1:0] armed_low;
    logic [FIELD_TEMP_W-1:0] armed_high;
    bit                      wl_flag;
    bit                      wl_present;
    bit                      wired_present;
    bit                      charging;
    logic [15:0]             nom_cur, nom_volt, red_cur, red_volt;
    logic [COUNT_W-1:0]      warm_n, cool_n, warm_n_wl, cool_n_wl;
    charge_result_t          expected_results[$];
    int                      errors;

    function new();
      foreach (zones[i]) zones[i] = '{default: '0};
      armed_low     = '0;
      armed_high    = '0;
      wl_flag       = 1'b0;
      wl_present    = 1'b0;
      wired_present = 1'b0;
      charging      = 1'b0;
      nom_cur       = '0;
      nom_volt      = '0;
      red_cur       = '0;
      red_volt      = '0;
      warm_n        = 5'd1;
      cool_n        = 5'd1;
      warm_n_wl     = 5'd0;
      cool_n_wl     = 5'd0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_NOM_CUR:  nom_cur   = val;
        REG_NOM_VOLT: nom_volt  = val;
        REG_RED_CUR:  red_cur   = val;
        REG_RED_VOLT: red_volt  = val;
        REG_WARM_CNT: warm_n    = val[COUNT_W-1:0];
        REG_COOL_CNT: cool_n    = val[COUNT_W-1:0];
        REG_WARM_WL:  warm_n_wl = val[COUNT_W-1:0];
        default:      cool_n_wl = val[COUNT_W-1:0];
      endcase
    endfunction

    function bit wireless_tables_on();
      return wl_flag && warm_n_wl != 0 && cool_n_wl != 0;
    endfunction

    function void arm_from(int unsigned slot);
      armed_low  = zones[slot].nlow;
      armed_high = zones[slot].nhigh;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the controller by one accepted item and queue the result it gives
    function void note_item(logic [S_TDATA_W-1:0] d, logic [S_TUSER_W-1:0] u);
      charge_result_t          r;
      zone_entry_t             e;
      logic [2:0]              op;
      logic [1:0]              sel;
      logic [FIELD_TEMP_W-1:0] key;
      bit                      warm, wl, changed;
      int unsigned             base, size, pos;
      op = u[2:0];
      sel = u[4:3];
      r = '{default: '0};
      r.status = STATUS_NO_CHANGE;
      case (op)
        OP_LOAD: begin
          zones[int'(sel) * TABLE_DEPTH_DEF + int'(d[3:0])] =
            '{thr: d[15:4], nlow: d[27:16], nhigh: d[39:28], act: d[41:40], hlth: d[45:42]};
          r.status = STATUS_STORED;
        end
        OP_START: begin
          arm_from(int'(TBL_WIRED_WARM) * TABLE_DEPTH_DEF);
          r.status = STATUS_REARMED;
        end
        OP_WARM, OP_COOL: begin
          warm = (op == OP_WARM);
          wl = wireless_tables_on();
          // cool tables sit right after their warm tables
          base = ((wl ? int'(TBL_WL_WARM) : int'(TBL_WIRED_WARM)) + (warm ? 0 : 1))
                 * TABLE_DEPTH_DEF;
          size = warm ? (wl ? warm_n_wl : warm_n) : (wl ? cool_n_wl : cool_n);
          key = warm ? armed_high : armed_low;
          if (size > TABLE_DEPTH_DEF) size = TABLE_DEPTH_DEF;
          // top-down search, entry 0 is the fallback
          pos = (size == 0) ? 0 : size - 1;
          while (pos > 0 && zones[base + pos].thr != key) pos--;
          e = zones[base + pos];
          arm_from(base + pos);
          r.action = e.act;
          r.health = e.hlth;
          r.health_valid = 1'b1;
          r.status = STATUS_REARMED;
          case (e.act)
            ACT_ENABLE: begin
              charging = 1'b1;
              r.limits_valid = 1'b1;
              r.cur_limit = nom_cur;
              r.voltage_mv = nom_volt;
            end
            ACT_DECREASE: begin
              charging = 1'b1;
              r.limits_valid = 1'b1;
              r.cur_limit = red_cur;
              r.voltage_mv = red_volt;
            end
            ACT_STOP: charging = 1'b0;
            default:  r.shutdown_req = 1'b1;
          endcase
        end
        OP_CHARGER: begin
          changed = 1'b0;
          if (d[46] != wl_present) begin
            wl_present = d[46];
            changed = 1'b1;
          end
          // wired presence only counts while wireless is gone
          if (!wl_present && d[47] != wired_present) begin
            wired_present = d[47];
            changed = 1'b1;
          end
          if (changed && (wl_present || wired_present)) begin
            charging = 1'b1;
            r.limits_valid = 1'b1;
            r.cur_limit = nom_cur;
            r.voltage_mv = nom_volt;
            wl_flag = wl_present;
            arm_from(int'(wl_present ? TBL_WL_WARM : TBL_WIRED_WARM) * TABLE_DEPTH_DEF);
            r.status = STATUS_REARMED;
          end
        end
        default: ;
      endcase
      r.low_thr = armed_low;
      r.high_thr = armed_high;
      r.charge_enable = charging;
      r.wireless_tables = wireless_tables_on();
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [M_TDATA_W-1:0] d, logic [M_TUSER_W-1:0] u);
      charge_result_t want;
      if (expected_results.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, u[1:0]);
      compare_field("low_threshold", $signed(want.low_thr), $signed(d[11:0]));
      compare_field("high_threshold", $signed(want.high_thr), $signed(d[23:12]));
      compare_field("action", want.action, d[25:24]);
      compare_field("health", want.health, d[29:26]);
      compare_field("health_valid", want.health_valid, d[30]);
      compare_field("charge_enable", want.charge_enable, d[31]);
      compare_field("limits_valid", want.limits_valid, d[32]);
      compare_field("current_limit_ma", want.cur_limit, d[48:33]);
      compare_field("voltage_limit_mv", want.voltage_mv, d[64:49]);
      compare_field("shutdown_request", want.shutdown_req, d[65]);
      compare_field("using_wireless_tables", want.wireless_tables, d[66]);
      compare_field("tdata_pad", want.pad, d[71:67]);
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
// Testbench top for battery_thermal_zone_charge_control_core: directed and random items,
// random stalls on both streams, results checked by btzcc_check_pkg::zone_check_board.
// Depends on btzcc_pkg, btzcc_check_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btzcc_pkg::*;
  import btzcc_check_pkg::*;

  localparam logic [2:0] OP_SPARE       = 3'd5;   // first unused operation code
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 177;
  localparam int SETTLE_CYCLES = TABLE_DEPTH_DEF + 4;
  localparam int STALL_LIMIT   = 4000;

  typedef struct {
    logic [2:0]  op;
    logic [1:0]  sel;
    logic [3:0]  idx;
    logic [11:0] thr, nlow, nhigh;
    logic [1:0]  act;
    logic [3:0]  hlth;
    logic        wl, wd;
  } zone_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  zone_check_board board = new();
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_cycles = 0;
  logic [11:0] temp_pool[8];

  battery_thermal_zone_charge_control_core dut (.*);

  always #6 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Sample handshakes and register writes, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) board.note_item(s_tdata, s_tuser);
      if (cfg_we) board.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Temperatures drawn from a small set so searches actually hit entries;
  // the two extremes stay in the set
  function automatic void refresh_pool();
    temp_pool[0] = 12'h800;
    temp_pool[1] = 12'h7FF;
    for (int i = 2; i < 8; i++) temp_pool[i] = 12'($urandom);
  endfunction

  function automatic logic [11:0] pool_temp();
    return temp_pool[$urandom_range(0, 7)];
  endfunction

  function automatic zone_item_t noise_item(logic [2:0] op);
    zone_item_t it;
    it.op    = op;
    it.sel   = 2'($urandom);
    it.idx   = 4'($urandom);
    it.thr   = 12'($urandom);
    it.nlow  = 12'($urandom);
    it.nhigh = 12'($urandom);
    it.act   = 2'($urandom);
    it.hlth  = 4'($urandom);
    it.wl    = 1'($urandom);
    it.wd    = 1'($urandom);
    return it;
  endfunction

  function automatic zone_item_t pool_entry(logic [1:0] sel, logic [3:0] idx);
    zone_item_t it;
    it = noise_item(OP_LOAD);
    it.sel   = sel;
    it.idx   = idx;
    it.thr   = pool_temp();
    it.nlow  = pool_temp();
    it.nhigh = pool_temp();
    return it;
  endfunction

  // Mostly crossings and well-formed reloads, some presence changes and noise
  function automatic zone_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) return noise_item(pick[0] ? OP_WARM : OP_COOL);
    if (pick < 64) return pool_entry(2'($urandom), 4'($urandom));
    if (pick < 76) return noise_item(OP_CHARGER);
    if (pick < 84) return noise_item(OP_START);
    if (pick < 94) return noise_item(OP_LOAD);
    return noise_item(OP_SPARE + 3'($urandom_range(0, 2)));
  endfunction

  // Counts: mostly in range, sometimes zero or above the table depth
  function automatic logic [4:0] rand_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 5'd0;
    if (pick < 20) return 5'($urandom_range(TABLE_DEPTH_DEF + 1, 31));
    return 5'($urandom_range(1, TABLE_DEPTH_DEF));
  endfunction

  task automatic send_item(input zone_item_t it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, $urandom_range(1, 20))) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {it.sel, it.op};
    s_tdata  <= {it.wd, it.wl, it.hlth, it.act, it.nhigh, it.nlow, it.thr, it.idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_op(input logic [2:0] op);
    send_item(noise_item(op));
  endtask

  task automatic send_charger(input logic wl, input logic wd);
    zone_item_t it;
    it = noise_item(OP_CHARGER);
    it.wl = wl;
    it.wd = wd;
    send_item(it);
  endtask

  task automatic send_entry(input logic [1:0] sel, input logic [3:0] idx, input int thr,
                            input int nl, input int nh, input logic [1:0] act,
                            input logic [3:0] hl);
    zone_item_t it;
    it = noise_item(OP_LOAD);
    it.sel   = sel;
    it.idx   = idx;
    it.thr   = thr[11:0];
    it.nlow  = nl[11:0];
    it.nhigh = nh[11:0];
    it.act   = act;
    it.hlth  = hl;
    send_item(it);
  endtask

  // Hold the input side until every result is back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] nc, input logic [15:0] nv,
                              input logic [15:0] rc, input logic [15:0] rv,
                              input logic [4:0] wc, input logic [4:0] cc,
                              input logic [4:0] wwl, input logic [4:0] cwl);
    write_cfg(REG_NOM_CUR, nc);
    write_cfg(REG_NOM_VOLT, nv);
    write_cfg(REG_RED_CUR, rc);
    write_cfg(REG_RED_VOLT, rv);
    write_cfg(REG_WARM_CNT, {11'd0, wc});
    write_cfg(REG_COOL_CNT, {11'd0, cc});
    write_cfg(REG_WARM_WL, {11'd0, wwl});
    write_cfg(REG_COOL_WL, {11'd0, cwl});
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    refresh_pool();
    program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 5'd16, 5'd16, 5'd16, 5'd16);

    // Fill every table entry so no search ever reads an unwritten slot
    for (int t = 0; t < 4; t++)
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) send_item(pool_entry(2'(t), 4'(i)));

    // Directed: a chain of wired warm entries covering every action
    send_entry(TBL_WIRED_WARM, 4'd0, 0, -2048, 100, ACT_ENABLE, 4'd1);
    send_entry(TBL_WIRED_WARM, 4'd5, 100, -2048, 200, ACT_DECREASE, 4'd2);
    send_entry(TBL_WIRED_WARM, 4'd15, 200, -100, 300, ACT_STOP, 4'd4);
    send_entry(TBL_WIRED_WARM, 4'd9, 300, 2047, 2047, ACT_SHUTDOWN, 4'd15);
    send_op(OP_START);
    repeat (4) send_op(OP_WARM);
    send_op(OP_COOL);
    // wireless plug-in, repeat with no change, then wired plug, unplug, replug
    send_charger(1'b1, 1'b0);
    send_charger(1'b1, 1'b1);
    send_op(OP_WARM);
    send_op(OP_COOL);
    send_charger(1'b0, 1'b1);
    send_charger(1'b0, 1'b0);
    send_charger(1'b0, 1'b1);
    for (int k = 0; k < 3; k++) send_op(OP_SPARE + 3'(k));
    // zero counts fall back to entry 0
    settle();
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 5'd0, 5'd0, 5'd0, 5'd0);
    send_op(OP_WARM);
    send_op(OP_COOL);
    // counts above the depth are clamped
    settle();
    program_regs(16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF,
                 5'd31, 5'd31, 5'd31, 5'd31);
    send_charger(1'b1, 1'b0);
    send_op(OP_WARM);
    send_op(OP_COOL);

    // Random segments, each with its own register setting; the stall pattern changes every second segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg / 2)
        0:       begin tx_idle_pct = 27; rx_idle_pct = 81; end
        1:       begin tx_idle_pct = 81; rx_idle_pct = 27; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      refresh_pool();
      case (seg)
        1:       program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              5'd16, 5'd16, 5'd16, 5'd16);
        4:       program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              5'd1, 5'd1, 5'd1, 5'd1);
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              rand_count(), rand_count(), rand_count(), rand_count());
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 2) wait_for_drain();
        send_item(random_item());
      end
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
